FILE: hw/rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared constants and types of the sphere particle initialiser.
// ----------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int EPS_RAW   = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam int EPS_LSB   = (EPS_RAW != 0) ? EPS_RAW : 1;

	localparam logic [30:0] Q30_ONE    = 31'd1 << 30;
	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

	typedef enum logic [1:0] {
		REG_END_RADIUS = 2'd0,
		REG_MASS_VALUE = 2'd1,
		REG_SPIN_SPEED = 2'd2
	} cfg_reg_t;

	typedef logic signed [31:0] trig_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spi_isqrt.sv
// ----------------------------------------------------------------------------
// spi_isqrt
// Pipelined floor integer square root, one result bit per stage, with a
// side payload that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_isqrt #(
	parameter int IN_W  = 61,
	parameter int PAY_W = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        in_vld,
	input  wire logic [IN_W-1:0]             in_val,
	input  wire logic [PAY_W-1:0]            in_pay,
	output logic                             out_vld,
	output logic [(IN_W+1)/2-1:0]            out_root,
	output logic [PAY_W-1:0]                 out_pay
);

	localparam int RT_W = (IN_W + 1) / 2;
	localparam int V_W  = 2 * RT_W;

	logic [V_W-1:0]   v_s   [RT_W+1];
	logic [V_W-1:0]   r_s   [RT_W+1];
	logic [PAY_W-1:0] pay_s [RT_W+1];
	logic             vld_s [RT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s[0]   <= V_W'(in_val);
			r_s[0]   <= '0;
			pay_s[0] <= in_pay;
		end
	end

	for (genvar i = 1; i <= RT_W; i++) begin : g_step
		localparam int BP = RT_W - i;
		logic [V_W:0]   bit_c;
		logic [V_W:0]   sum_c;
		logic           ge_c;
		logic [V_W-1:0] v_c;
		logic [V_W-1:0] r_c;

		always_comb begin
			bit_c = (V_W+1)'(1) << (2 * BP);
			sum_c = {1'b0, r_s[i-1]} + bit_c;
			ge_c  = {1'b0, v_s[i-1]} >= sum_c;
			if (ge_c) begin
				v_c = v_s[i-1] - sum_c[V_W-1:0];
				r_c = (r_s[i-1] >> 1) + bit_c[V_W-1:0];
			end else begin
				v_c = v_s[i-1];
				r_c = r_s[i-1] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				v_s[i]   <= v_c;
				r_s[i]   <= r_c;
				pay_s[i] <= pay_s[i-1];
			end
		end
	end

	assign out_vld  = vld_s[RT_W];
	assign out_root = r_s[RT_W][RT_W-1:0];
	assign out_pay  = pay_s[RT_W];

endmodule

`default_nettype wire

FILE: hw/rtl/spi_sincos.sv
// ----------------------------------------------------------------------------
// spi_sincos
// Pipelined sine and cosine of a fraction of a turn: quadrant split, Taylor
// series in Q30 with truncated terms, clamp, quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_sincos import spi_pkg::*; #(
	parameter int PAY_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_vld,
	input  wire logic [15:0]      in_turn,
	input  wire logic [PAY_W-1:0] in_pay,
	output logic                  out_vld,
	output trig_t                 out_cos,
	output trig_t                 out_sin,
	output logic [PAY_W-1:0]      out_pay
);

	localparam int ITERS = 9;
	localparam logic signed [35:0] ACC_ONE = 36'sd1073741824;

	typedef struct packed {
		logic [1:0]       quad;
		logic [PAY_W-1:0] pay;
	} ctx_t;

	// angle stage
	logic [46:0] ang_c;
	logic [30:0] x_s1;
	ctx_t        ctx_s1;
	logic        vld_s1;

	assign ang_c = 47'(in_turn[13:0]) * 47'(TWO_PI_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1        <= ang_c[46:16];
			ctx_s1.quad <= in_turn[15:14];
			ctx_s1.pay  <= in_pay;
		end
	end

	// series state between iterations, entry zero is the seed
	logic [31:0]        it_x2  [ITERS+1];
	logic [31:0]        it_ts  [ITERS+1];
	logic [31:0]        it_tc  [ITERS+1];
	logic signed [35:0] it_ss  [ITERS+1];
	logic signed [35:0] it_cs  [ITERS+1];
	ctx_t               it_ctx [ITERS+1];
	logic               it_vld [ITERS+1];

	logic [61:0] xsq_c;
	assign xsq_c = 62'(x_s1) * 62'(x_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_vld[0] <= 1'b0;
		end else if (adv) begin
			it_vld[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_x2[0]  <= xsq_c[61:30];
			it_ts[0]  <= 32'(x_s1);
			it_tc[0]  <= 32'(Q30_ONE);
			it_ss[0]  <= 36'(x_s1);
			it_cs[0]  <= ACC_ONE;
			it_ctx[0] <= ctx_s1;
		end
	end

	for (genvar k = 0; k < ITERS; k++) begin : g_term
		localparam int KM = k + 1;
		localparam int DS = (2 * KM) * (2 * KM + 1);
		localparam int DC = (2 * KM - 1) * (2 * KM);
		localparam int LS = $clog2(DS);
		localparam int LC = $clog2(DC);
		localparam logic [63:0] MS = ((64'd1 << (32 + LS)) + 64'(DS) - 64'd1) / 64'(DS);
		localparam logic [63:0] MC = ((64'd1 << (32 + LC)) + 64'(DC) - 64'd1) / 64'(DC);

		logic [63:0]        pts_sa;
		logic [63:0]        ptc_sa;
		logic [31:0]        x2_sa;
		logic signed [35:0] ss_sa;
		logic signed [35:0] cs_sa;
		ctx_t               ctx_sa;
		logic               vld_sa;

		logic [65:0] qs_c;
		logic [65:0] qc_c;
		logic [31:0] ts_c;
		logic [31:0] tc_c;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sa      <= 1'b0;
				it_vld[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sa      <= it_vld[k];
				it_vld[k+1] <= vld_sa;
			end
		end

		always_comb begin
			qs_c = 66'(pts_sa[61:30]) * 66'(MS[33:0]);
			qc_c = 66'(ptc_sa[61:30]) * 66'(MC[33:0]);
			ts_c = 32'(qs_c >> (32 + LS));
			tc_c = 32'(qc_c >> (32 + LC));
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pts_sa <= 64'(it_ts[k]) * 64'(it_x2[k]);
				ptc_sa <= 64'(it_tc[k]) * 64'(it_x2[k]);
				x2_sa  <= it_x2[k];
				ss_sa  <= it_ss[k];
				cs_sa  <= it_cs[k];
				ctx_sa <= it_ctx[k];

				it_x2[k+1]  <= x2_sa;
				it_ts[k+1]  <= ts_c;
				it_tc[k+1]  <= tc_c;
				it_ctx[k+1] <= ctx_sa;
				if ((KM % 2) == 1) begin
					it_ss[k+1] <= ss_sa - $signed(36'(ts_c));
					it_cs[k+1] <= cs_sa - $signed(36'(tc_c));
				end else begin
					it_ss[k+1] <= ss_sa + $signed(36'(ts_c));
					it_cs[k+1] <= cs_sa + $signed(36'(tc_c));
				end
			end
		end
	end

	// clamp to [0, 1]
	logic [30:0] c0_sc;
	logic [30:0] s0_sc;
	ctx_t        ctx_sc;
	logic        vld_sc;

	function automatic logic [30:0] clamp_one(input logic signed [35:0] v);
		logic [30:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > ACC_ONE) begin
			r = Q30_ONE;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc  <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			vld_sc  <= it_vld[ITERS];
			out_vld <= vld_sc;
		end
	end

	trig_t c0_c;
	trig_t s0_c;
	assign c0_c = trig_t'(c0_sc);
	assign s0_c = trig_t'(s0_sc);

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_sc  <= clamp_one(it_cs[ITERS]);
			s0_sc  <= clamp_one(it_ss[ITERS]);
			ctx_sc <= it_ctx[ITERS];

			out_pay <= ctx_sc.pay;
			case (ctx_sc.quad)
				2'd0: begin
					out_cos <= c0_c;
					out_sin <= s0_c;
				end
				2'd1: begin
					out_cos <= -s0_c;
					out_sin <= c0_c;
				end
				2'd2: begin
					out_cos <= -c0_c;
					out_sin <= -s0_c;
				end
				default: begin
					out_cos <= s0_c;
					out_sin <= -c0_c;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sphere_particle_initializer_top.sv
// ----------------------------------------------------------------------------
// sphere_particle_initializer_top
// Places one particle per transaction at a random point inside a sphere and
// gives it a tangential velocity of programmable speed.
// ----------------------------------------------------------------------------
// One particle enters per clock while the output is free or being taken. The
// whole path is a single pipeline that moves as one, so a stall on the output
// side halts every stage without loss. The depth is set by the two square
// roots of one bit per stage (32 and 20 stages), the nine-term sine and cosine
// series (22 stages) and the 26-stage restoring divider that normalises the
// velocity.
`default_nettype none

module sphere_particle_initializer_top import spi_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [47:0]  s_tdata,   // u_polar, u_azimuth, u_radius
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [167:0]      m_tdata,   // pos_x, pos_y, pos_z, mass_out, vel_x, vel_y, vel_z
	output logic              m_tlast,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int QW = 25;

	typedef struct packed {
		logic        ctneg;
		logic [30:0] cabs;
		logic [33:0] rad;
		logic [15:0] ua;
		logic        last;
	} p1_t;

	typedef struct packed {
		logic [33:0] a;
		logic [33:0] rad;
		logic        ctneg;
		logic [30:0] cabs;
		logic        last;
	} p2_t;

	typedef struct packed {
		logic [64:0] mx;
		logic [64:0] my;
		logic [64:0] mz;
		logic        nx;
		logic        ny;
		logic        nz;
		logic        last;
	} pr_t;

	typedef struct packed {
		logic signed [18:0] px;
		logic signed [18:0] py;
		logic signed [18:0] pz;
		logic [2:0][18:0]   mag;
		logic [2:0]         neg;
		logic               last;
	} tg_t;

	typedef struct packed {
		logic [2:0][43:0]   rem;
		logic [2:0][QW-1:0] quo;
		logic [2:0]         ovf;
		logic [2:0]         neg;
		logic [19:0]        d;
		logic signed [18:0] px;
		logic signed [18:0] py;
		logic signed [18:0] pz;
		logic               last;
	} dv_t;

	// configuration
	logic [17:0] end_radius_q;
	logic [31:0] mass_value_q;
	logic [23:0] spin_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_radius_q <= 18'd65536;
			mass_value_q <= 32'd437387;
			spin_speed_q <= 24'd655360;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_END_RADIUS: end_radius_q <= cfg_data[17:0];
				REG_MASS_VALUE: mass_value_q <= cfg_data;
				REG_SPIN_SPEED: spin_speed_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic m_tvalid_q;
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	function automatic logic signed [18:0] sat_pos(input logic neg, input logic [18:0] p);
		logic signed [18:0] r;
		if (neg) begin
			r = (p > 19'h40000) ? 19'sh40000 : 19'(-p);
		end else begin
			r = (p > 19'h3FFFF) ? 19'sh3FFFF : p;
		end
		return r;
	endfunction

	function automatic logic [18:0] abs19(input logic signed [18:0] v);
		return v[18] ? 19'(-v) : 19'(v);
	endfunction

	function automatic logic signed [24:0] sat_vel(input logic neg, input logic [24:0] p);
		logic signed [24:0] r;
		if (neg) begin
			r = (p > 25'h1000000) ? 25'sh1000000 : 25'(-p);
		end else begin
			r = (p > 25'hFFFFFF) ? 25'shFFFFFF : p;
		end
		return r;
	endfunction

	// s1: polar cosine and radius
	logic [15:0] up_c;
	logic [15:0] ua_c;
	logic [15:0] ur_c;
	logic [30:0] upsh_c;
	p1_t         p1_c;

	assign up_c   = s_tdata[15:0];
	assign ua_c   = s_tdata[31:16];
	assign ur_c   = s_tdata[47:32];
	assign upsh_c = {up_c, 15'd0};

	always_comb begin
		p1_c.ctneg = !up_c[15];
		p1_c.cabs  = up_c[15] ? (upsh_c - Q30_ONE) : (Q30_ONE - upsh_c);
		p1_c.rad   = 34'(ur_c) * 34'(end_radius_q);
		p1_c.ua    = ua_c;
		p1_c.last  = s_tlast;
	end

	p1_t         p1_s1;
	logic        vld_s1;
	p1_t         p1_s2;
	logic [60:0] sq_s2;
	logic        vld_s2;
	logic [61:0] csq_c;

	assign csq_c = 62'(p1_s1.cabs) * 62'(p1_s1.cabs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s1 <= p1_c;
			p1_s2 <= p1_s1;
			sq_s2 <= (61'd1 << 60) - csq_c[60:0];
		end
	end

	// sine of the polar angle
	logic        sr_vld;
	logic [30:0] sr_root;
	logic [$bits(p1_t)-1:0] sr_pay;
	p1_t         sr_p;

	spi_isqrt #(
		.IN_W  (61),
		.PAY_W ($bits(p1_t))
	) u_sin_polar (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s2),
		.in_val   (sq_s2),
		.in_pay   (p1_s2),
		.out_vld  (sr_vld),
		.out_root (sr_root),
		.out_pay  (sr_pay)
	);

	assign sr_p = sr_pay;

	// s3: planar radius
	logic [64:0] ap_c;
	p2_t         p2_s3;
	logic [15:0] ua_s3;
	logic        vld_s3;

	assign ap_c = 65'(sr_p.rad) * 65'(sr_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= sr_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s3.a     <= ap_c[63:30];
			p2_s3.rad   <= sr_p.rad;
			p2_s3.ctneg <= sr_p.ctneg;
			p2_s3.cabs  <= sr_p.cabs;
			p2_s3.last  <= sr_p.last;
			ua_s3       <= sr_p.ua;
		end
	end

	// azimuth
	logic  tr_vld;
	trig_t tr_cos;
	trig_t tr_sin;
	logic [$bits(p2_t)-1:0] tr_pay;
	p2_t   tr_p;

	spi_sincos #(
		.PAY_W ($bits(p2_t))
	) u_azimuth (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s3),
		.in_turn (ua_s3),
		.in_pay  (p2_s3),
		.out_vld (tr_vld),
		.out_cos (tr_cos),
		.out_sin (tr_sin),
		.out_pay (tr_pay)
	);

	assign tr_p = tr_pay;

	// s4: position products, s5: round and saturate
	logic [30:0] cmag_c;
	logic [30:0] smag_c;
	assign cmag_c = tr_cos[31] ? 31'(-tr_cos) : tr_cos[30:0];
	assign smag_c = tr_sin[31] ? 31'(-tr_sin) : tr_sin[30:0];

	pr_t                pr_s4;
	logic               vld_s4;
	logic signed [18:0] px_s5;
	logic signed [18:0] py_s5;
	logic signed [18:0] pz_s5;
	logic               last_s5;
	logic               vld_s5;
	logic [64:0]        rx_c;
	logic [64:0]        ry_c;
	logic [64:0]        rz_c;

	assign rx_c = pr_s4.mx + (65'd1 << 45);
	assign ry_c = pr_s4.my + (65'd1 << 45);
	assign rz_c = pr_s4.mz + (65'd1 << 45);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= tr_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s4.mx   <= 65'(tr_p.a) * 65'(cmag_c);
			pr_s4.my   <= 65'(tr_p.a) * 65'(smag_c);
			pr_s4.mz   <= 65'(tr_p.rad) * 65'(tr_p.cabs);
			pr_s4.nx   <= tr_cos[31];
			pr_s4.ny   <= tr_sin[31];
			pr_s4.nz   <= tr_p.ctneg;
			pr_s4.last <= tr_p.last;

			px_s5   <= sat_pos(pr_s4.nx, rx_c[64:46]);
			py_s5   <= sat_pos(pr_s4.ny, ry_c[64:46]);
			pz_s5   <= sat_pos(pr_s4.nz, rz_c[64:46]);
			last_s5 <= pr_s4.last;
		end
	end

	// s6: tangent, s7: squares, s8: sum
	logic nzp_c;
	logic pypos_c;
	tg_t  tg_c;

	assign nzp_c   = (px_s5 != 19'sd0) || (py_s5 != 19'sd0);
	assign pypos_c = !py_s5[18] && (py_s5 != 19'sd0);

	always_comb begin
		tg_c.px     = px_s5;
		tg_c.py     = py_s5;
		tg_c.pz     = pz_s5;
		tg_c.last   = last_s5;
		tg_c.mag[0] = nzp_c ? abs19(py_s5) : 19'd0;
		tg_c.neg[0] = nzp_c && pypos_c;
		tg_c.mag[1] = nzp_c ? abs19(px_s5) : abs19(pz_s5);
		tg_c.neg[1] = nzp_c ? px_s5[18] : pz_s5[18];
		tg_c.mag[2] = nzp_c ? 19'd0 : abs19(py_s5);
		tg_c.neg[2] = !nzp_c && pypos_c;
	end

	tg_t              tg_s6;
	logic             vld_s6;
	tg_t              tg_s7;
	logic [2:0][37:0] sqv_s7;
	logic             vld_s7;
	tg_t              tg_s8;
	logic [37:0]      sum_s8;
	logic             vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tg_s6 <= tg_c;
			tg_s7 <= tg_s6;
			for (int l = 0; l < 3; l++) begin
				sqv_s7[l] <= 38'(tg_s6.mag[l]) * 38'(tg_s6.mag[l]);
			end
			tg_s8  <= tg_s7;
			sum_s8 <= sqv_s7[0] + sqv_s7[1] + sqv_s7[2];
		end
	end

	// tangent length
	logic        ln_vld;
	logic [18:0] ln_root;
	logic [$bits(tg_t)-1:0] ln_pay;
	tg_t         ln_p;

	spi_isqrt #(
		.IN_W  (38),
		.PAY_W ($bits(tg_t))
	) u_tangent_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s8),
		.in_val   (sum_s8),
		.in_pay   (tg_s8),
		.out_vld  (ln_vld),
		.out_root (ln_root),
		.out_pay  (ln_pay)
	);

	assign ln_p = ln_pay;

	// s9: divisor and rounded numerators
	logic [19:0]      d_c;
	tg_t              tg_s9;
	logic [19:0]      d_s9;
	logic [2:0][43:0] num_s9;
	logic             vld_s9;

	assign d_c = 20'(ln_root) + 20'(EPS_LSB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= ln_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tg_s9 <= ln_p;
			d_s9  <= d_c;
			for (int l = 0; l < 3; l++) begin
				num_s9[l] <= 44'(ln_p.mag[l]) * 44'(spin_speed_q) + 44'(d_c >> 1);
			end
		end
	end

	// restoring divider, one quotient bit per stage
	dv_t  dv_s     [QW+1];
	logic dv_vld_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				dv_s[0].rem[l] <= num_s9[l];
				dv_s[0].quo[l] <= '0;
				dv_s[0].ovf[l] <= {1'b0, num_s9[l]} >= {d_s9, 25'd0};
			end
			dv_s[0].neg  <= tg_s9.neg;
			dv_s[0].d    <= d_s9;
			dv_s[0].px   <= tg_s9.px;
			dv_s[0].py   <= tg_s9.py;
			dv_s[0].pz   <= tg_s9.pz;
			dv_s[0].last <= tg_s9.last;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int BP = QW - j;
		dv_t         nxt_c;
		logic [44:0] dsh_c;

		always_comb begin
			nxt_c = dv_s[j-1];
			dsh_c = 45'(dv_s[j-1].d) << BP;
			for (int l = 0; l < 3; l++) begin
				if ({1'b0, dv_s[j-1].rem[l]} >= dsh_c) begin
					nxt_c.rem[l]     = dv_s[j-1].rem[l] - dsh_c[43:0];
					nxt_c.quo[l][BP] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[j] <= dv_vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j] <= nxt_c;
			end
		end
	end

	// output register
	logic signed [24:0] vel_c [3];
	logic [167:0]       m_tdata_q;
	logic               m_tlast_q;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			vel_c[l] = sat_vel(dv_s[QW].neg[l], dv_s[QW].ovf[l] ? '1 : dv_s[QW].quo[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= dv_vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {4'd0, vel_c[2], vel_c[1], vel_c[0], mass_value_q,
				dv_s[QW].pz, dv_s[QW].py, dv_s[QW].px};
			m_tlast_q <= dv_s[QW].last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_vel_z_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[163:139] == 25'd0))
		else $error("vel_z nonzero");

	a_vel_x_on_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[37:0] == 38'd0)) |-> (m_tdata[113:89] == 25'd0))
		else $error("vel_x nonzero on polar axis");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted transaction not captured");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(vld_s1) && $stable(dv_vld_s[QW]))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

FILE: bench/sphere_particle_initializer_top_test.sv
// ----------------------------------------------------------------------------
// sphere_particle_initializer_top_test
// Drives uniform fractions into the particle initialiser and checks every
// position, mass and velocity against a bit-exact fixed-point particle
// calculator. The run covers a directed table, then random bursts under
// several register settings, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_particle_initializer_top_test import spi_pkg::*;;

	typedef struct {
		logic signed [18:0] px, py, pz;
		logic        [31:0] mass;
		logic signed [24:0] vx, vy, vz;
		logic               last;
	} particle_t;

	typedef struct {
		logic [15:0] up, ua, ur;
		logic        last;
		bit          zero_rad;
	} seed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;   // u_polar, u_azimuth, u_radius
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [167:0] m_tdata;       // pos_x, pos_y, pos_z, mass_out, vel_x, vel_y, vel_z
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_END_RADIUS;
	logic [31:0] cfg_data = '0;

	longint unsigned radius_reg, mass_reg, speed_reg;
	particle_t pending_particles[$];
	int errors = 0;
	int particles_sent = 0;
	int particles_seen = 0;
	int stall_mode = 0;
	int cycle_count = 0;

	sphere_particle_initializer_top dut (.*);

	always #5 clk = ~clk;

	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clamp_signed(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// sin and cos of x in [0, pi/2], Q30 in and out
	function automatic void quarter_wave(longint unsigned x, output longint c, output longint s);
		longint unsigned x2, ts, tc, k;
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		s = longint'(x);
		c = longint'(64'd1 << 30);
		for (k = 1; k <= 24 && (ts != 0 || tc != 0); k++) begin
			ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
			tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
			if (k[0]) begin
				s -= longint'(ts);
				c -= longint'(tc);
			end else begin
				s += longint'(ts);
				c += longint'(tc);
			end
		end
		if (s < 0) s = 0;
		if (s > (longint'(1) <<< 30)) s = longint'(1) <<< 30;
		if (c < 0) c = 0;
		if (c > (longint'(1) <<< 30)) c = longint'(1) <<< 30;
	endfunction

	function automatic longint place_axis(longint unsigned a, longint m);
		longint unsigned mag, p;
		mag = m < 0 ? longint'(-m) : longint'(m);
		p = (a * mag + (64'd1 << 45)) >> 46;
		return clamp_signed(m < 0 ? -longint'(p) : longint'(p), 19);
	endfunction

	function automatic longint spin_axis(longint v, longint unsigned d);
		longint unsigned mag, p;
		mag = v < 0 ? longint'(-v) : longint'(v);
		p = (mag * speed_reg + d / 2) / d;
		return clamp_signed(v < 0 ? -longint'(p) : longint'(p), 25);
	endfunction

	function automatic particle_t compute_particle(logic [15:0] up, logic [15:0] ua,
			logic [15:0] ur, logic last);
		particle_t res;
		longint ct, c0, s0, cp, sp, px, py, pz, vx, vy, vz;
		longint unsigned cabs, st, rad, a, d;
		ct = longint'({48'd0, up} << 15) - (longint'(1) <<< 30);
		cabs = ct < 0 ? longint'(-ct) : longint'(ct);
		st = root_floor((64'd1 << 60) - cabs * cabs);
		rad = {48'd0, ur} * radius_reg;
		a = (rad * st) >> 30;
		quarter_wave({50'd0, ua[13:0]} * 64'd6746518852 / 65536, c0, s0);
		case (ua[15:14])
			2'd0: begin cp = c0;  sp = s0;  end
			2'd1: begin cp = -s0; sp = c0;  end
			2'd2: begin cp = -c0; sp = -s0; end
			default: begin cp = s0; sp = -c0; end
		endcase
		px = place_axis(a, cp);
		py = place_axis(a, sp);
		pz = place_axis(rad, ct);
		if (px != 0 || py != 0) begin
			vx = -py; vy = px; vz = 0;
		end else begin
			vx = 0; vy = pz; vz = -py;
		end
		d = root_floor(longint'(vx * vx + vy * vy + vz * vz)) + 64'(EPS_LSB);
		res.px = px[18:0];
		res.py = py[18:0];
		res.pz = pz[18:0];
		res.mass = mass_reg[31:0];
		res.vx = 25'(spin_axis(vx, d));
		res.vy = 25'(spin_axis(vy, d));
		res.vz = 25'(spin_axis(vz, d));
		res.last = last;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("[%0t] particle %0d: %s got %0d expected %0d", $realtime, particles_seen,
			what, got, want);
	endtask

	// receiver: stall pattern switches between free, random and periodic
	always @(negedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 700 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= arst_n;
			1: m_tready <= arst_n && ($urandom_range(0, 9) < 6);
			default: m_tready <= arst_n && (cycle_count % 7 < 3);
		endcase
	end

	always @(posedge clk) begin
		particle_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_particles.size() == 0) begin
				errors++;
				$display("[%0t] unexpected output transaction", $realtime);
			end else begin
				want = pending_particles.pop_front();
				if ($signed(m_tdata[18:0]) != want.px)
					report_mismatch("pos_x", $signed(m_tdata[18:0]), want.px);
				if ($signed(m_tdata[37:19]) != want.py)
					report_mismatch("pos_y", $signed(m_tdata[37:19]), want.py);
				if ($signed(m_tdata[56:38]) != want.pz)
					report_mismatch("pos_z", $signed(m_tdata[56:38]), want.pz);
				if (m_tdata[88:57] != want.mass)
					report_mismatch("mass_out", m_tdata[88:57], want.mass);
				if ($signed(m_tdata[113:89]) != want.vx)
					report_mismatch("vel_x", $signed(m_tdata[113:89]), want.vx);
				if ($signed(m_tdata[138:114]) != want.vy)
					report_mismatch("vel_y", $signed(m_tdata[138:114]), want.vy);
				if ($signed(m_tdata[163:139]) != want.vz)
					report_mismatch("vel_z", $signed(m_tdata[163:139]), want.vz);
				if (m_tlast != want.last)
					report_mismatch("last", m_tlast, want.last);
				if (m_tdata[167:164] != 4'd0)
					report_mismatch("pad", m_tdata[167:164], 0);
			end
			particles_seen++;
		end
	end

	// present one particle and hold until the transaction completes
	task automatic send_particle(logic [15:0] up, logic [15:0] ua, logic [15:0] ur,
			logic last, bit typed_zero);
		particle_t want;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {ur, ua, up};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		if (typed_zero) begin
			want = '{px: 0, py: 0, pz: 0, mass: mass_reg[31:0], vx: 0, vy: 0, vz: 0,
				last: last};
		end else
			want = compute_particle(up, ua, ur, last);
		pending_particles.push_back(want);
		particles_sent++;
	endtask

	task automatic idle_input(int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_pipeline;
		idle_input(1);
		while (pending_particles.size() != 0) @(posedge clk);
		repeat (130) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, longint unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[31:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_END_RADIUS: radius_reg = value & 64'h3FFFF;
			REG_MASS_VALUE: mass_reg = value & 64'hFFFF_FFFF;
			default: speed_reg = value & 64'hFF_FFFF;
		endcase
	endtask

	task automatic load_settings(longint unsigned r, longint unsigned m, longint unsigned s);
		drain_pipeline();
		write_reg(REG_END_RADIUS, r);
		write_reg(REG_MASS_VALUE, m);
		write_reg(REG_SPIN_SPEED, s);
	endtask

	task automatic random_burst_phase(int count);
		int burst;
		logic [15:0] up, ua, ur;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			up = 16'($urandom);
			ua = 16'($urandom);
			ur = 16'($urandom);
			case ($urandom_range(0, 9))
				0: up = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				1: ua = {2'($urandom_range(0, 3)), 14'h0} |
					{2'b00, ($urandom_range(0, 1) ? 14'h3FFF : 14'h0)};
				2: ur = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
				3: begin up = 16'h8000; ua = {2'($urandom_range(0, 3)), 14'h0}; end
				default: ;
			endcase
			send_particle(up, ua, ur, $urandom_range(0, 7) == 0, 1'b0);
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 12));
			end else
				burst--;
		end
	endtask

	seed_row_t seed_table[] = '{
		'{16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1},
		'{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1},
		'{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1},
		'{16'h8000, 16'h0000, 16'h8000, 1'b0, 1'b0},
		'{16'h8000, 16'h4000, 16'h8000, 1'b0, 1'b0},
		'{16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0},
		'{16'h8000, 16'hC000, 16'h8000, 1'b1, 1'b0},
		'{16'h8000, 16'h3FFF, 16'hFFFF, 1'b0, 1'b0},
		'{16'h8000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
		'{16'h0000, 16'h1234, 16'hFFFF, 1'b0, 1'b0},
		'{16'hFFFF, 16'h9ABC, 16'hFFFF, 1'b0, 1'b0},
		'{16'h0000, 16'h0000, 16'h0001, 1'b0, 1'b0},
		'{16'hFFFF, 16'h0000, 16'h0001, 1'b0, 1'b0},
		'{16'h0001, 16'h2000, 16'hFFFF, 1'b0, 1'b0},
		'{16'hFFFE, 16'hE000, 16'hFFFF, 1'b0, 1'b0},
		'{16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0},
		'{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0},
		'{16'h8000, 16'h0000, 16'h0001, 1'b0, 1'b0},
		'{16'h7FFF, 16'h4001, 16'h0002, 1'b1, 1'b0}
	};

	initial begin
		radius_reg = 64'd65536;
		mass_reg = 64'd437387;
		speed_reg = 64'd655360;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (seed_table[i])
			send_particle(seed_table[i].up, seed_table[i].ua, seed_table[i].ur,
				seed_table[i].last, seed_table[i].zero_rad);
		random_burst_phase(200);

		load_settings(64'h3FFFF, 64'hFFFF_FFFF, 64'hFF_FFFF);
		foreach (seed_table[i])
			send_particle(seed_table[i].up, seed_table[i].ua, seed_table[i].ur,
				seed_table[i].last, seed_table[i].zero_rad);
		random_burst_phase(150);

		load_settings(64'd0, 64'd0, 64'd0);
		random_burst_phase(100);

		load_settings(64'd1, 64'd1, 64'd1);
		random_burst_phase(100);

		load_settings(64'($urandom_range(0, 262143)), 64'($urandom),
			64'($urandom_range(0, 16777215)));
		random_burst_phase(200);

		load_settings(64'd65536, 64'd437387, 64'd655360);
		random_burst_phase(200);

		idle_input(1);
		fork
			while (pending_particles.size() != 0) @(posedge clk);
			begin
				repeat (20000) @(posedge clk);
				$display("[%0t] outputs still outstanding: %0d", $realtime,
					pending_particles.size());
				errors++;
			end
		join_any
		disable fork;
		repeat (150) @(posedge clk);

		$display("Sent %0d particles, checked %0d, over six register settings", particles_sent,
			particles_seen);
		$display("including radius, mass and speed at zero, one and full scale");
		if (errors == 0 && pending_particles.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
